// ----- rtl/id_handle_allocator_map_top_assert.svh -----
// ----------------------------------------------------------------------------
// id_handle_allocator_map_top_assert
// Assertion macros for the ID allocator map, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef ID_HANDLE_ALLOCATOR_MAP_TOP_ASSERT_SVH
`define ID_HANDLE_ALLOCATOR_MAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IHA_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ihamap: invariant check failed");
`define IHA_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ihamap: same-cycle check failed");
`define IHA_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ihamap: next-cycle check failed");
`else
`define IHA_ASSERT(lbl, expr)
`define IHA_IMPLY(lbl, ante, cons)
`define IHA_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ihamap_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ihamap_pkg
// Types, sizes and search helpers for the ID allocator map.
// ----------------------------------------------------------------------------
package ihamap_pkg;

	localparam int ID_COUNT   = 256;
	localparam int DATA_WIDTH = 64;
	localparam int ID_W       = $clog2(ID_COUNT);
	localparam int START_W    = ID_W + 1;
	localparam int GRP_W      = 16;
	localparam int GRP_CNT    = ID_COUNT / GRP_W;
	localparam int LOW_W      = $clog2(GRP_W);
	localparam int GIDX_W     = $clog2(GRP_CNT);

	typedef enum logic [2:0] {
		KIND_ALLOC   = 3'd0,
		KIND_FIND    = 3'd1,
		KIND_REPLACE = 3'd2,
		KIND_REMOVE  = 3'd3,
		KIND_CLEAR   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_RESP
	} state_t;

	function automatic logic [LOW_W-1:0] low_in_grp(input logic [GRP_W-1:0] v);
		logic [LOW_W-1:0] r;
		r = '0;
		for (int i = GRP_W - 1; i >= 0; i--) begin
			if (v[i]) r = LOW_W'(i);
		end
		return r;
	endfunction

	function automatic logic [GIDX_W-1:0] low_grp(input logic [GRP_CNT-1:0] v);
		logic [GIDX_W-1:0] r;
		r = '0;
		for (int i = GRP_CNT - 1; i >= 0; i--) begin
			if (v[i]) r = GIDX_W'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/id_handle_allocator_map_top.sv -----
// A request is taken in ST_IDLE; ST_SCAN registers the per-group flags of the
// two-stage lowest-free search over the bound flags, ST_PICK registers the result
// with the registered data memory read, and ST_RESP moves it to the output register
// once that is free. No new request is taken before that; one is then taken while the previous result waits there.
// Reset (arst_n low) clears all bound flags at once; the data memory is not
// cleared and its read data is used only for bound IDs.
`default_nettype none
`include "id_handle_allocator_map_top_assert.svh"
// ----------------------------------------------------------------------------
// id_handle_allocator_map_top
// ID-to-data map with lowest-free allocation above a floor, find, replace,
// remove and clear all, built around a 64-bit data memory and a flag vector.
// ----------------------------------------------------------------------------
module id_handle_allocator_map_top
	import ihamap_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  id,
	input  wire logic [8:0]  floor,
	input  wire logic [63:0] data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       result_id,
	output logic [63:0]      result_data
);

	state_t                  st_q, st_d;
	logic [2:0]              kind_q;
	logic [ID_W-1:0]         id_q;
	logic [START_W-1:0]      start_q;
	logic [DATA_WIDTH-1:0]   data_q;
	logic [ID_COUNT-1:0]     bound_q;
	logic [DATA_WIDTH-1:0]   mem_q [ID_COUNT];
	logic [DATA_WIDTH-1:0]   rd_data_q;
	logic [GRP_CNT-1:0]      grp_any_q;
	logic [LOW_W-1:0]        grp_low_q [GRP_CNT];
	status_t                 res_status_q;
	logic [7:0]              res_id_q;
	logic [63:0]             res_data_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [7:0]              out_id_q;
	logic [63:0]             out_data_q;

	logic                    in_xfer;
	logic                    out_load;
	logic [GRP_CNT-1:0]      grp_any_d;
	logic [LOW_W-1:0]        grp_low_d [GRP_CNT];
	logic [GIDX_W-1:0]       pick_grp;
	logic [ID_W-1:0]         pick_id;
	logic                    pick_hit;
	logic                    in_range;
	logic                    id_bound;
	status_t                 res_status_d;
	logic [7:0]              res_id_d;
	logic [63:0]             res_data_d;
	logic                    flag_set;
	logic                    flag_clr;
	logic                    flag_clr_all;
	logic [ID_W-1:0]         flag_addr;
	logic                    mem_we;
	logic [ID_W-1:0]         mem_waddr;
	logic [START_W-1:0]      start_d;

	assign in_xfer  = in_valid && in_ready;
	assign out_load = (st_q == ST_RESP) && (!out_valid_q || out_ready);
	assign start_d  = floor[8] ? '0 : (START_W'(floor[7:0]) + START_W'(1));
	assign in_range = (32'(id_q) < ID_COUNT);
	assign id_bound = in_range && bound_q[id_q];

	always_comb begin
		logic [GRP_W-1:0] elig;
		for (int g = 0; g < GRP_CNT; g++) begin
			for (int j = 0; j < GRP_W; j++) begin
				elig[j] = !bound_q[g*GRP_W + j] &&
					(START_W'(g*GRP_W + j) >= start_q);
			end
			grp_any_d[g] = |elig;
			grp_low_d[g] = low_in_grp(elig);
		end
	end

	assign pick_hit = |grp_any_q;
	assign pick_grp = low_grp(grp_any_q);
	assign pick_id  = ID_W'({pick_grp, grp_low_q[pick_grp]});

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_xfer) st_d = ST_SCAN;
			ST_SCAN: st_d = ST_PICK;
			ST_PICK: st_d = ST_RESP;
			ST_RESP: if (out_load) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (st_q == ST_IDLE);
		res_status_d = STATUS_OK;
		res_id_d     = 8'(id_q);
		res_data_d   = '0;
		flag_set     = 1'b0;
		flag_clr     = 1'b0;
		flag_clr_all = 1'b0;
		flag_addr    = id_q;
		mem_we       = 1'b0;
		mem_waddr    = id_q;
		if (st_q == ST_PICK) begin
			unique case (kind_q)
				KIND_ALLOC: begin
					if (pick_hit) begin
						res_id_d  = 8'(pick_id);
						flag_set  = 1'b1;
						flag_addr = pick_id;
						mem_we    = 1'b1;
						mem_waddr = pick_id;
					end else begin
						res_status_d = STATUS_FULL;
						res_id_d     = '0;
					end
				end
				KIND_FIND: begin
					if (id_bound) res_data_d = 64'(rd_data_q);
					else res_status_d = STATUS_NOT_FOUND;
				end
				KIND_REPLACE: begin
					if (id_bound) begin
						res_data_d = 64'(rd_data_q);
						mem_we     = 1'b1;
					end else begin
						res_status_d = STATUS_NOT_FOUND;
					end
				end
				KIND_REMOVE: flag_clr = in_range;
				KIND_CLEAR: flag_clr_all = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			bound_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (flag_clr_all) bound_q <= '0;
			else if (flag_set) bound_q[flag_addr] <= 1'b1;
			else if (flag_clr) bound_q[flag_addr] <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= kind;
			id_q    <= ID_W'(id);
			start_q <= start_d;
			data_q  <= data[DATA_WIDTH-1:0];
		end
		if (st_q == ST_SCAN) begin
			grp_any_q <= grp_any_d;
			grp_low_q <= grp_low_d;
		end
		if (st_q == ST_PICK) begin
			res_status_q <= res_status_d;
			res_id_q     <= res_id_d;
			res_data_q   <= res_data_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_data_q   <= res_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= data_q;
		rd_data_q <= mem_q[id_q];
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign result_id   = out_id_q;
	assign result_data = out_data_q;

	`IHA_NEXT(a_alloc_sets_flag, (st_q == ST_PICK) && (kind_q == KIND_ALLOC) && pick_hit, bound_q[$past(pick_id)])
	`IHA_IMPLY(a_alloc_above_floor, (st_q == ST_PICK) && (kind_q == KIND_ALLOC) && pick_hit, START_W'(pick_id) >= start_q)
	`IHA_IMPLY(a_full_zero_id, out_valid && (status == STATUS_FULL), result_id == 8'd0)
	`IHA_NEXT(a_resp_loads_out, out_load, out_valid_q && (st_q == ST_IDLE))
	`IHA_ASSERT(a_ready_only_idle, !in_ready || (st_q == ST_IDLE))

endmodule
`default_nettype wire
